// ===== rtl/delta_timer_queue_core_defines.svh =====
// Assertion macros for the delta timer queue core.
// Depends on nothing; taken in by files that assert by `include.
`ifndef DELTA_TIMER_QUEUE_CORE_DEFINES_SVH
`define DELTA_TIMER_QUEUE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define DTQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("delta timer queue: same-cycle check failed");
`define DTQ_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("delta timer queue: next-cycle check failed");
`else
`define DTQ_ASSERT_IMP(label, clk, rst, ante, cons)
`define DTQ_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/dtq_pkg.sv =====
// Types and codes shared by the delta timer queue core.
// Depends on nothing.
`default_nettype none
package dtq_pkg;

   localparam int THREAD_ID_BITS = 6;
   localparam int TICKS_BITS     = 32;

   localparam logic [1:0] FUNC_ENQUEUE = 2'd0;
   localparam logic [1:0] FUNC_POP     = 2'd1;
   localparam logic [1:0] FUNC_DETACH  = 2'd2;
   localparam logic [1:0] FUNC_QUERY   = 2'd3;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_TIME = 2'd1;
   localparam logic [1:0] STATUS_QUEUED   = 2'd2;
   localparam logic [1:0] STATUS_MISSING  = 2'd3;

   typedef struct packed {
      logic [1:0]                func;
      logic [THREAD_ID_BITS-1:0] thread_id;
      logic [TICKS_BITS-1:0]     ticks;
   } req_type;

   typedef struct packed {
      logic [THREAD_ID_BITS-1:0] result_thread;
      logic [1:0]                status;
      logic                      is_queued;
      logic [TICKS_BITS-1:0]     head_delta;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_WALK_INS,
      ST_INS_FIX,
      ST_INS_TAIL,
      ST_WALK_DEL,
      ST_DEL_FOLLOW,
      ST_DEL_CLR
   } state_type;

endpackage
`default_nettype wire

// ===== rtl/dtq_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on nothing.
`default_nettype none
module dtq_ram #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6,
   parameter int WIDTH  = 32
) (
   input  wire logic              clock,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/delta_timer_queue_core.sv =====
// Delta-list timer queue: sequencer, head/tail registers and two link/delta RAMs.
// Depends on dtq_pkg, dtq_ram and delta_timer_queue_core_defines.svh.
//
//   channel   | ports                    | handshake
//   ----------+--------------------------+-------------------------------
//   request   | start, busy, req_word    | taken when start && !busy
//   response  | rsp_valid, rsp_word      | one-cycle strobe, no backpressure
//
// Query, empty-pop, enqueue into an empty list and rejected words answer from ST_CHECK.
// Other enqueue and detach words walk the list one entry per cycle through the RAM read port,
// bounded by a guard counter at NUM_THREADS entries; pop and detach of the head do not walk.
// After reset a clearing pass writes every link entry, with busy high.
// The response cannot be stalled; busy is low again in the strobe cycle.
`default_nettype none
`include "delta_timer_queue_core_defines.svh"
module delta_timer_queue_core #(
   parameter int NUM_THREADS = 64,
   parameter int DELTA_BITS  = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire dtq_pkg::req_type req_word,
   output logic                  rsp_valid,
   output dtq_pkg::rsp_type      rsp_word
);

   localparam int IDX_W   = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
   localparam int LINK_W  = IDX_W + 1;
   localparam int GUARD_W = IDX_W + 1;

   dtq_pkg::state_type state_ff, state_in;

   logic [1:0]                         func_ff, func_in;
   logic [dtq_pkg::THREAD_ID_BITS-1:0] tid_ff, tid_in;
   logic [IDX_W-1:0]                   id_ff, id_in;
   logic                               valid_ff, valid_in;
   logic [DELTA_BITS-1:0]              rem_ff, rem_in;
   logic [IDX_W-1:0]                   p_ff, p_in;
   logic [IDX_W-1:0]                   prev_ff, prev_in;
   logic                               first_ff, first_in;
   logic [GUARD_W-1:0]                 guard_ff, guard_in;
   logic [IDX_W-1:0]                   tnext_ff, tnext_in;
   logic [DELTA_BITS-1:0]              tdelta_ff, tdelta_in;
   logic [DELTA_BITS-1:0]              dfix_ff, dfix_in;
   logic [IDX_W-1:0]                   head_ff, head_in;
   logic [IDX_W-1:0]                   tail_ff, tail_in;
   logic                               empty_ff, empty_in;
   logic [DELTA_BITS-1:0]              hdelta_ff, hdelta_in;
   logic [IDX_W-1:0]                   clr_ff, clr_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   dtq_pkg::rsp_type                   rsp_ff, rsp_in;

   logic [IDX_W-1:0]      rd_addr;
   logic [LINK_W-1:0]     link_q;
   logic [DELTA_BITS-1:0] delta_q;
   logic                  link_we;
   logic [IDX_W-1:0]      link_wa;
   logic [LINK_W-1:0]     link_wd;
   logic                  delta_we;
   logic [IDX_W-1:0]      delta_wa;
   logic [DELTA_BITS-1:0] delta_wd;

   logic                  link_flag;
   logic [IDX_W-1:0]      link_next;
   logic                  req_in_range;
   logic                  rem_gt;
   logic [DELTA_BITS-1:0] rem_sub;
   logic [DELTA_BITS-1:0] d_sub;
   logic [DELTA_BITS-1:0] d_sum;
   logic [IDX_W-1:0]      tgt;

   dtq_ram #(.DEPTH(NUM_THREADS), .ADDR_W(IDX_W), .WIDTH(LINK_W)) u_link_ram (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (link_q),
      .wr_en   (link_we),
      .wr_addr (link_wa),
      .wr_data (link_wd)
   );

   dtq_ram #(.DEPTH(NUM_THREADS), .ADDR_W(IDX_W), .WIDTH(DELTA_BITS)) u_delta_ram (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (delta_q),
      .wr_en   (delta_we),
      .wr_addr (delta_wa),
      .wr_data (delta_wd)
   );

   assign link_flag    = link_q[IDX_W];
   assign link_next    = link_q[IDX_W-1:0];
   assign req_in_range = int'(req_word.thread_id) < NUM_THREADS;
   assign rem_gt       = rem_ff > delta_q;
   assign rem_sub      = rem_ff - delta_q;
   assign d_sub        = delta_q - rem_ff;
   assign d_sum        = delta_q + tdelta_ff;
   assign tgt          = (func_ff == dtq_pkg::FUNC_POP) ? head_ff : id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dtq_pkg::ST_CLEAR;
         clr_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         empty_ff     <= 1'b1;
         hdelta_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         empty_ff     <= empty_in;
         hdelta_ff    <= hdelta_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      tid_ff    <= tid_in;
      id_ff     <= id_in;
      valid_ff  <= valid_in;
      rem_ff    <= rem_in;
      p_ff      <= p_in;
      prev_ff   <= prev_in;
      first_ff  <= first_in;
      guard_ff  <= guard_in;
      tnext_ff  <= tnext_in;
      tdelta_ff <= tdelta_in;
      dfix_ff   <= dfix_in;
      rsp_ff    <= rsp_in;
   end

   always_comb begin
      logic do_unlink;
      do_unlink    = 1'b0;
      state_in     = state_ff;
      func_in      = func_ff;
      tid_in       = tid_ff;
      id_in        = id_ff;
      valid_in     = valid_ff;
      rem_in       = rem_ff;
      p_in         = p_ff;
      prev_in      = prev_ff;
      first_in     = first_ff;
      guard_in     = guard_ff;
      tnext_in     = tnext_ff;
      tdelta_in    = tdelta_ff;
      dfix_in      = dfix_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      empty_in     = empty_ff;
      hdelta_in    = hdelta_ff;
      clr_in       = clr_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rd_addr      = p_ff;
      link_we      = 1'b0;
      link_wa      = id_ff;
      link_wd      = '0;
      delta_we     = 1'b0;
      delta_wa     = id_ff;
      delta_wd     = rem_ff;

      case (state_ff)
         dtq_pkg::ST_CLEAR: begin
            link_we = 1'b1;
            link_wa = clr_ff;
            link_wd = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(NUM_THREADS - 1)) begin
               state_in = dtq_pkg::ST_IDLE;
            end
         end
         dtq_pkg::ST_IDLE: begin
            if (start) begin
               func_in  = req_word.func;
               tid_in   = req_word.thread_id;
               id_in    = IDX_W'(req_word.thread_id);
               valid_in = req_in_range;
               rem_in   = DELTA_BITS'(req_word.ticks);
               rd_addr  = (req_word.func == dtq_pkg::FUNC_POP) ? head_ff
                                                              : IDX_W'(req_word.thread_id);
               state_in = dtq_pkg::ST_CHECK;
            end
         end
         dtq_pkg::ST_CHECK: begin
            rsp_in.result_thread = tid_ff;
            rsp_in.status        = dtq_pkg::STATUS_OK;
            rsp_in.is_queued     = 1'b0;
            case (func_ff)
               dtq_pkg::FUNC_ENQUEUE: begin
                  if (!valid_ff || rem_ff == '0) begin
                     rsp_in.status    = dtq_pkg::STATUS_BAD_TIME;
                     rsp_in.is_queued = valid_ff & link_flag;
                     rsp_valid_in     = 1'b1;
                     state_in         = dtq_pkg::ST_IDLE;
                  end else if (link_flag) begin
                     rsp_in.status    = dtq_pkg::STATUS_QUEUED;
                     rsp_in.is_queued = 1'b1;
                     rsp_valid_in     = 1'b1;
                     state_in         = dtq_pkg::ST_IDLE;
                  end else if (empty_ff) begin
                     link_we          = 1'b1;
                     link_wd          = {1'b1, {IDX_W{1'b0}}};
                     delta_we         = 1'b1;
                     head_in          = id_ff;
                     tail_in          = id_ff;
                     empty_in         = 1'b0;
                     hdelta_in        = rem_ff;
                     rsp_in.is_queued = 1'b1;
                     rsp_valid_in     = 1'b1;
                     state_in         = dtq_pkg::ST_IDLE;
                  end else begin
                     p_in     = head_ff;
                     prev_in  = head_ff;
                     first_in = 1'b1;
                     guard_in = '0;
                     rd_addr  = head_ff;
                     state_in = dtq_pkg::ST_WALK_INS;
                  end
               end
               dtq_pkg::FUNC_POP: begin
                  if (empty_ff) begin
                     rsp_in.result_thread = '0;
                     rsp_in.status        = dtq_pkg::STATUS_MISSING;
                     rsp_valid_in         = 1'b1;
                     state_in             = dtq_pkg::ST_IDLE;
                  end else begin
                     id_in                = head_ff;
                     tid_in               = dtq_pkg::THREAD_ID_BITS'(head_ff);
                     rsp_in.result_thread = dtq_pkg::THREAD_ID_BITS'(head_ff);
                     do_unlink            = 1'b1;
                  end
               end
               dtq_pkg::FUNC_DETACH: begin
                  if (!valid_ff || !link_flag) begin
                     rsp_in.status = dtq_pkg::STATUS_MISSING;
                     rsp_valid_in  = 1'b1;
                     state_in      = dtq_pkg::ST_IDLE;
                  end else begin
                     do_unlink = 1'b1;
                  end
               end
               default: begin
                  rsp_in.status    = valid_ff ? dtq_pkg::STATUS_OK : dtq_pkg::STATUS_MISSING;
                  rsp_in.is_queued = valid_ff & link_flag;
                  rsp_valid_in     = 1'b1;
                  state_in         = dtq_pkg::ST_IDLE;
               end
            endcase
            if (do_unlink) begin
               tnext_in  = link_next;
               tdelta_in = delta_q;
               if (tgt == head_ff) begin
                  if (tgt == tail_ff) begin
                     empty_in     = 1'b1;
                     link_we      = 1'b1;
                     link_wa      = tgt;
                     link_wd      = {1'b0, link_next};
                     rsp_valid_in = 1'b1;
                     state_in     = dtq_pkg::ST_IDLE;
                  end else begin
                     head_in  = link_next;
                     rd_addr  = link_next;
                     state_in = dtq_pkg::ST_DEL_FOLLOW;
                  end
               end else begin
                  prev_in  = head_ff;
                  guard_in = '0;
                  rd_addr  = head_ff;
                  state_in = dtq_pkg::ST_WALK_DEL;
               end
            end
         end
         dtq_pkg::ST_WALK_INS: begin
            if (rem_gt) begin
               rem_in = rem_sub;
               if (p_ff == tail_ff || guard_ff >= GUARD_W'(NUM_THREADS)) begin
                  link_we  = 1'b1;
                  link_wd  = {1'b1, {IDX_W{1'b0}}};
                  delta_we = 1'b1;
                  delta_wd = rem_sub;
                  state_in = dtq_pkg::ST_INS_TAIL;
               end else begin
                  prev_in  = p_ff;
                  first_in = 1'b0;
                  p_in     = link_next;
                  guard_in = guard_ff + 1'b1;
                  rd_addr  = link_next;
               end
            end else begin
               link_we  = 1'b1;
               link_wd  = {1'b1, p_ff};
               delta_we = 1'b1;
               delta_wd = rem_ff;
               dfix_in  = d_sub;
               if (first_ff) begin
                  head_in   = id_ff;
                  hdelta_in = rem_ff;
               end
               state_in = dtq_pkg::ST_INS_FIX;
            end
         end
         dtq_pkg::ST_INS_FIX: begin
            delta_we = 1'b1;
            delta_wa = p_ff;
            delta_wd = dfix_ff;
            if (!first_ff) begin
               link_we = 1'b1;
               link_wa = prev_ff;
               link_wd = {1'b1, id_ff};
            end
            rsp_in.status    = dtq_pkg::STATUS_OK;
            rsp_in.is_queued = 1'b1;
            rsp_valid_in     = 1'b1;
            state_in         = dtq_pkg::ST_IDLE;
         end
         dtq_pkg::ST_INS_TAIL: begin
            link_we          = 1'b1;
            link_wa          = tail_ff;
            link_wd          = {1'b1, id_ff};
            tail_in          = id_ff;
            rsp_in.status    = dtq_pkg::STATUS_OK;
            rsp_in.is_queued = 1'b1;
            rsp_valid_in     = 1'b1;
            state_in         = dtq_pkg::ST_IDLE;
         end
         dtq_pkg::ST_WALK_DEL: begin
            if (prev_ff != tail_ff && link_next != id_ff
                && guard_ff < GUARD_W'(NUM_THREADS)) begin
               prev_in  = link_next;
               guard_in = guard_ff + 1'b1;
               rd_addr  = link_next;
            end else begin
               link_we = 1'b1;
               link_wa = prev_ff;
               link_wd = {link_flag, tnext_ff};
               if (id_ff == tail_ff) begin
                  tail_in  = prev_ff;
                  state_in = dtq_pkg::ST_DEL_CLR;
               end else begin
                  rd_addr  = tnext_ff;
                  state_in = dtq_pkg::ST_DEL_FOLLOW;
               end
            end
         end
         dtq_pkg::ST_DEL_FOLLOW: begin
            delta_we = 1'b1;
            delta_wa = tnext_ff;
            delta_wd = d_sum;
            if (tnext_ff == head_ff) begin
               hdelta_in = d_sum;
            end
            link_we          = 1'b1;
            link_wd          = {1'b0, tnext_ff};
            rsp_in.status    = dtq_pkg::STATUS_OK;
            rsp_in.is_queued = 1'b0;
            rsp_valid_in     = 1'b1;
            state_in         = dtq_pkg::ST_IDLE;
         end
         dtq_pkg::ST_DEL_CLR: begin
            link_we          = 1'b1;
            link_wd          = {1'b0, tnext_ff};
            rsp_in.status    = dtq_pkg::STATUS_OK;
            rsp_in.is_queued = 1'b0;
            rsp_valid_in     = 1'b1;
            state_in         = dtq_pkg::ST_IDLE;
         end
         default: begin
            state_in = dtq_pkg::ST_IDLE;
         end
      endcase

      if (rsp_valid_in) begin
         rsp_in.head_delta = empty_in ? '0 : dtq_pkg::TICKS_BITS'(hdelta_in);
      end
   end

   assign busy      = (state_ff != dtq_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   `DTQ_ASSERT_IMP(a_rsp_when_idle, clock, reset, rsp_valid, !busy)
   `DTQ_ASSERT_NXT(a_busy_after_start, clock, reset, start && !busy, busy && !rsp_valid)
   `DTQ_ASSERT_IMP(a_empty_head_zero, clock, reset, rsp_valid && empty_ff, rsp_word.head_delta == '0)
   `DTQ_ASSERT_IMP(a_queued_flag, clock, reset, rsp_valid && rsp_word.status == dtq_pkg::STATUS_QUEUED, rsp_word.is_queued)

endmodule
`default_nettype wire

// ===== dv/delta_timer_queue_checker.sv =====
// Checker for the delta timer queue core: predicts each response word from the request words.
// Compares every strobed response word field by field with the oldest prediction.
// Depends on dtq_pkg.
module delta_timer_queue_checker
   import dtq_pkg::*;
#(
   parameter int NUM_THREADS = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_word,
   input  logic    rsp_valid,
   input  rsp_type rsp_word,
   output int      fail_count,
   output int      awaited
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [THREAD_ID_BITS-1:0] link_mem   [NUM_THREADS];
   logic [TICKS_BITS-1:0]     delta_mem  [NUM_THREADS];
   logic                      queued_mem [NUM_THREADS];
   logic [THREAD_ID_BITS-1:0] head_id;
   logic [THREAD_ID_BITS-1:0] tail_id;
   logic                      list_empty;

   rsp_type awaited_rsps[$];
   int      errors = 0;

   function automatic void unlink_thread(logic [THREAD_ID_BITS-1:0] id);
      logic [THREAD_ID_BITS-1:0] prev;
      int guard;
      prev  = head_id;
      guard = 0;
      if (id == head_id) begin
         if (id == tail_id) begin
            list_empty = 1'b1;
         end else begin
            head_id = link_mem[id];
            delta_mem[head_id] = delta_mem[head_id] + delta_mem[id];
         end
      end else begin
         while (prev != tail_id && link_mem[prev] != id && guard < NUM_THREADS) begin
            prev = link_mem[prev];
            guard++;
         end
         link_mem[prev] = link_mem[id];
         if (id == tail_id) begin
            tail_id = prev;
         end else begin
            delta_mem[link_mem[id]] = delta_mem[link_mem[id]] + delta_mem[id];
         end
      end
      queued_mem[id] = 1'b0;
      delta_mem[id]  = '0;
   endfunction

   function automatic void insert_thread(logic [THREAD_ID_BITS-1:0] id,
                                         logic [TICKS_BITS-1:0] rem);
      logic [THREAD_ID_BITS-1:0] p;
      logic [THREAD_ID_BITS-1:0] prev;
      logic first;
      int guard;
      p     = head_id;
      prev  = head_id;
      first = 1'b1;
      guard = 0;
      queued_mem[id] = 1'b1;
      if (list_empty) begin
         list_empty    = 1'b0;
         head_id       = id;
         tail_id       = id;
         delta_mem[id] = rem;
         link_mem[id]  = '0;
         return;
      end
      forever begin
         if (rem > delta_mem[p]) begin
            rem = rem - delta_mem[p];
            if (p == tail_id || guard >= NUM_THREADS) begin
               delta_mem[id]     = rem;
               link_mem[id]      = '0;
               link_mem[tail_id] = id;
               tail_id           = id;
               return;
            end
            prev  = p;
            first = 1'b0;
            p     = link_mem[p];
            guard++;
         end else begin
            if (first) begin
               head_id = id;
            end else begin
               link_mem[prev] = id;
            end
            link_mem[id]  = p;
            delta_mem[id] = rem;
            delta_mem[p]  = delta_mem[p] - rem;
            return;
         end
      end
   endfunction

   function automatic rsp_type predict_timer_op(req_type w);
      rsp_type r;
      r.result_thread = w.thread_id;
      r.status        = STATUS_OK;
      r.is_queued     = 1'b0;
      case (w.func)
         FUNC_ENQUEUE: begin
            if (w.ticks == '0) begin
               r.status    = STATUS_BAD_TIME;
               r.is_queued = queued_mem[w.thread_id];
            end else if (queued_mem[w.thread_id]) begin
               r.status    = STATUS_QUEUED;
               r.is_queued = 1'b1;
            end else begin
               insert_thread(w.thread_id, w.ticks);
               r.is_queued = 1'b1;
            end
         end
         FUNC_POP: begin
            if (list_empty) begin
               r.status        = STATUS_MISSING;
               r.result_thread = '0;
            end else begin
               r.result_thread = head_id;
               unlink_thread(head_id);
            end
         end
         FUNC_DETACH: begin
            if (!queued_mem[w.thread_id]) begin
               r.status = STATUS_MISSING;
            end else begin
               unlink_thread(w.thread_id);
            end
         end
         default: begin
            r.is_queued = queued_mem[w.thread_id];
         end
      endcase
      r.head_delta = list_empty ? '0 : delta_mem[head_id];
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < NUM_THREADS; i++) begin
            link_mem[i]   = '0;
            delta_mem[i]  = '0;
            queued_mem[i] = 1'b0;
         end
         head_id    = '0;
         tail_id    = '0;
         list_empty = 1'b1;
         awaited_rsps.delete();
      end else begin
         if (rsp_valid) begin
            if (awaited_rsps.size() == 0) begin
               $error("response word with none awaited: %h", rsp_word);
               errors++;
            end else begin
               want = awaited_rsps.pop_front();
               if (rsp_word.result_thread !== want.result_thread) begin
                  $error("result_thread: expected %0d, actual %0d",
                         want.result_thread, rsp_word.result_thread);
                  errors++;
               end
               if (rsp_word.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_word.status);
                  errors++;
               end
               if (rsp_word.is_queued !== want.is_queued) begin
                  $error("is_queued: expected %0d, actual %0d",
                         want.is_queued, rsp_word.is_queued);
                  errors++;
               end
               if (rsp_word.head_delta !== want.head_delta) begin
                  $error("head_delta: expected %0d, actual %0d",
                         want.head_delta, rsp_word.head_delta);
                  errors++;
               end
            end
         end
         if (start && !busy) begin
            awaited_rsps.push_back(predict_timer_op(req_word));
         end
      end
      awaited    <= awaited_rsps.size();
      fail_count <= errors;
   end

endmodule

// ===== dv/delta_timer_queue_core_tb.sv =====
// Testbench top for the delta timer queue core: clock, reset, request words and the verdict.
// Directed words first, then random enqueue, pop, detach and query words in fill/mix/drain phases.
// Depends on dtq_pkg, delta_timer_queue_core and delta_timer_queue_checker.
module delta_timer_queue_core_tb;
   import dtq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_THREADS  = 64;
   localparam int RANDOM_WORDS = 1300;
   localparam int QUIET_WORDS  = 200;
   localparam int STALL_LIMIT  = 2000;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_word;
   logic    rsp_valid;
   rsp_type rsp_word;
   int      fail_count;
   int      awaited;
   int      stall_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   delta_timer_queue_core #(
      .NUM_THREADS(NUM_THREADS),
      .DELTA_BITS (32)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_word (rsp_word)
   );

   delta_timer_queue_checker #(
      .NUM_THREADS(NUM_THREADS)
   ) u_checker (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .fail_count(fail_count),
      .awaited   (awaited)
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("delta_timer_queue_core: mismatch");
            $finish;
         end
      end
   end

   // hold start low for gap cycles, then present the word until taken
   task automatic send_word(logic [1:0] f, logic [THREAD_ID_BITS-1:0] id,
                            logic [TICKS_BITS-1:0] t, int gap);
      req_type w;
      w.func      = f;
      w.thread_id = id;
      w.ticks     = t;
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start    <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
   endtask

   function automatic logic [TICKS_BITS-1:0] random_ticks();
      int k;
      k = $urandom_range(0, 99);
      if (k < 5)  return '0;
      if (k < 60) return $urandom_range(1, 40);
      if (k < 78) return $urandom_range(1, 5000);
      if (k < 92) return $urandom;
      return 32'hFFFF_FFFF - $urandom_range(0, 3);
   endfunction

   initial begin
      int phase;
      int k;
      int gap;
      logic [1:0] f;
      reset    = 1'b1;
      start    = 1'b0;
      req_word = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_word(FUNC_POP,     6'd0,  32'd0,         0);
      send_word(FUNC_DETACH,  6'd5,  32'd7,         0);
      send_word(FUNC_QUERY,   6'd63, 32'hFFFF_FFFF, 0);
      send_word(FUNC_ENQUEUE, 6'd3,  32'd0,         0);
      send_word(FUNC_ENQUEUE, 6'd0,  32'd10,        0);
      send_word(FUNC_ENQUEUE, 6'd63, 32'hFFFF_FFFF, 1);
      send_word(FUNC_ENQUEUE, 6'd5,  32'd10,        0);
      send_word(FUNC_ENQUEUE, 6'd7,  32'd3,         0);
      send_word(FUNC_ENQUEUE, 6'd9,  32'd20,        2);
      send_word(FUNC_ENQUEUE, 6'h2A, 32'hAAAA_AAAA, 0);
      send_word(FUNC_ENQUEUE, 6'h15, 32'h5555_5555, 0);
      send_word(FUNC_ENQUEUE, 6'd0,  32'd4,         0);
      send_word(FUNC_ENQUEUE, 6'd1,  32'd1,         0);
      send_word(FUNC_QUERY,   6'd0,  32'd0,         0);
      send_word(FUNC_QUERY,   6'd2,  32'd0,         3);
      send_word(FUNC_DETACH,  6'd9,  32'd0,         0);
      send_word(FUNC_DETACH,  6'd63, 32'd0,         0);
      send_word(FUNC_DETACH,  6'd1,  32'd0,         0);
      send_word(FUNC_POP,     6'd0,  32'd0,         0);
      send_word(FUNC_DETACH,  6'd9,  32'd0,         0);
      send_word(FUNC_POP,     6'd0,  32'd0,         1);
      send_word(FUNC_POP,     6'd0,  32'd0,         0);
      send_word(FUNC_POP,     6'd0,  32'd0,         0);
      send_word(FUNC_POP,     6'd0,  32'd0,         0);
      send_word(FUNC_POP,     6'd0,  32'd0,         0);

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         phase = (i / 100) % 3;
         k = $urandom_range(0, 99);
         case (phase)
            0:       f = (k < 75) ? FUNC_ENQUEUE : (k < 85) ? FUNC_POP :
                         (k < 95) ? FUNC_DETACH : FUNC_QUERY;
            1:       f = (k < 50) ? FUNC_ENQUEUE : (k < 70) ? FUNC_POP :
                         (k < 90) ? FUNC_DETACH : FUNC_QUERY;
            default: f = (k < 20) ? FUNC_ENQUEUE : (k < 65) ? FUNC_POP :
                         (k < 90) ? FUNC_DETACH : FUNC_QUERY;
         endcase
         gap = 0;
         if (i < RANDOM_WORDS - QUIET_WORDS && $urandom_range(0, 99) < 30) begin
            gap = $urandom_range(1, 5);
         end
         send_word(f, THREAD_ID_BITS'($urandom_range(0, NUM_THREADS - 1)),
                   (f == FUNC_ENQUEUE) ? random_ticks() : $urandom, gap);
      end

      @(negedge clock);
      start <= 1'b0;
      @(posedge clock);
      while (awaited != 0) @(posedge clock);
      repeat (NUM_THREADS + 10) @(posedge clock);
      if (fail_count == 0) begin
         $display("delta_timer_queue_core: match");
      end else begin
         $display("delta_timer_queue_core: mismatch");
      end
      $finish;
   end

endmodule

// ===== delta_timer_queue_core.f =====
+incdir+rtl
rtl/dtq_pkg.sv
rtl/dtq_ram.sv
rtl/delta_timer_queue_core.sv
dv/delta_timer_queue_checker.sv
dv/delta_timer_queue_core_tb.sv
